[rtl/core/uart_registers_with_rx_fifo_assert.svh]
// Assertion macros shared by the UART register block RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef UART_REGISTERS_WITH_RX_FIFO_ASSERT_SVH
`define UART_REGISTERS_WITH_RX_FIFO_ASSERT_SVH

// The condition must hold in the same cycle as the antecedent.
`define URXF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the antecedent.
`define URXF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/urxf_pkg.sv]
// Package for the UART register block: request and response types, offsets and bit codes.
// No dependencies.
`timescale 1ns / 1ps

package urxf_pkg;

    localparam int unsigned URXF_FIFO_DEPTH = 16;

    // Operation codes of a request.
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PUSH  = 2'd2;

    // Register byte offsets.
    localparam logic [11:0] OFS_DR   = 12'h000;
    localparam logic [11:0] OFS_FR   = 12'h018;
    localparam logic [11:0] OFS_IBRD = 12'h024;
    localparam logic [11:0] OFS_FBRD = 12'h028;
    localparam logic [11:0] OFS_LCRH = 12'h02C;
    localparam logic [11:0] OFS_CR   = 12'h030;
    localparam logic [11:0] OFS_IFLS = 12'h034;
    localparam logic [11:0] OFS_IMSC = 12'h038;
    localparam logic [11:0] OFS_RIS  = 12'h03C;
    localparam logic [11:0] OFS_MIS  = 12'h040;
    localparam logic [11:0] OFS_ICR  = 12'h044;
    localparam logic [11:0] OFS_ID_BASE = 12'hFE0;

    // Flag register bits.
    localparam logic [31:0] FLAG_RXFE = 32'h0000_0010;
    localparam logic [31:0] FLAG_RXFF = 32'h0000_0040;
    localparam logic [31:0] FLAG_TXFE = 32'h0000_0080;

    // Interrupt bit positions.
    localparam int unsigned INT_RX_BIT = 4;
    localparam int unsigned INT_TX_BIT = 5;

    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] offset;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        irq;
    } rsp_t;

    // Peripheral and cell identification words, selected by offset bits 4:2.
    function automatic logic [7:0] id_word(input logic [2:0] sel);
        logic [7:0] w;
        case (sel)
            3'd0: w = 8'h11;
            3'd1: w = 8'h10;
            3'd2: w = 8'h14;
            3'd3: w = 8'h00;
            3'd4: w = 8'h0D;
            3'd5: w = 8'hF0;
            3'd6: w = 8'h05;
            default: w = 8'hB1;
        endcase
        return w;
    endfunction

endpackage

[rtl/core/urxf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module urxf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/uart_registers_with_rx_fifo.sv]
// UART register block top level: bus register decode, receive FIFO and response register.
// Depends on urxf_pkg, urxf_ram and uart_registers_with_rx_fifo_assert.svh.
`timescale 1ns / 1ps

// Each request (bus read, bus write or received-byte push) is decoded and executed in the
// cycle it is accepted, and its response appears in the response register on the next
// cycle, so the block sustains one request per clock while it is not held off. The only
// thing that holds off requests is a full response register whose consumer is stalling.
// Received bytes live in a RAM of FIFO_DEPTH bytes; its read port is always addressed at the
// head the FIFO will have after the current cycle, so the oldest byte is ready in the RAM
// output register when a data register read pops it. A push into an empty FIFO writes the
// entry being read in that same cycle, and a one-entry bypass register covers that case.
// The RAM needs no clearing after reset: the fill count guards every read. A write to the
// data register transmits its low byte on tx_byte in its response and raises the transmit
// interrupt; irq in each response reflects the masked status after that request.
module uart_registers_with_rx_fifo
    import urxf_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = URXF_FIFO_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

`include "uart_registers_with_rx_fifo_assert.svh"

    localparam int unsigned IDX_W  = $clog2(FIFO_DEPTH);
    localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);

    // Response register.
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    // FIFO pointers and occupancy.
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // Programmable registers.
    logic [31:0] cr_reg, cr_next;
    logic [31:0] lcrh_reg, lcrh_next;
    logic [31:0] ibrd_reg, ibrd_next;
    logic [31:0] fbrd_reg, fbrd_next;
    logic [31:0] ifls_reg, ifls_next;
    logic [31:0] imsc_reg, imsc_next;

    // Raw interrupt status; only the receive and transmit bits can ever be set.
    logic rx_int_reg, rx_int_next;
    logic tx_int_reg, tx_int_next;

    // Read-during-write bypass for the head entry.
    logic       byp_hit_reg, byp_hit_next;
    logic [7:0] byp_data_reg, byp_data_next;

    logic       accept;
    logic       fill_empty;
    logic       fill_full;
    logic       ram_we;
    logic [7:0] ram_rdata;
    logic [7:0] head_data;
    logic [31:0] status_now;
    logic [31:0] status_after;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(FIFO_DEPTH - 1)) ? '0 : p + IDX_W'(1);
    endfunction

    assign req_stall  = rsp_valid_reg && rsp_stall;
    assign accept     = req_valid && !req_stall;
    assign fill_empty = (fill_reg == '0);
    assign fill_full  = (fill_reg == FILL_W'(FIFO_DEPTH));
    assign head_data  = byp_hit_reg ? byp_data_reg : ram_rdata;

    always_comb
    begin
        status_now = '0;
        status_now[INT_RX_BIT] = rx_int_reg;
        status_now[INT_TX_BIT] = tx_int_reg;
    end

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        cr_next     = cr_reg;
        lcrh_next   = lcrh_reg;
        ibrd_next   = ibrd_reg;
        fbrd_next   = fbrd_reg;
        ifls_next   = ifls_reg;
        imsc_next   = imsc_reg;
        rx_int_next = rx_int_reg;
        tx_int_next = tx_int_reg;
        ram_we      = 1'b0;
        rsp_next    = '0;

        if (accept)
        begin
            case (req.operation)
                OP_READ:
                begin
                    if (req.offset >= OFS_ID_BASE && req.offset[1:0] == 2'b00)
                    begin
                        rsp_next.read_data = {24'b0, id_word(req.offset[4:2])};
                    end
                    else
                    begin
                        unique case (req.offset)
                            OFS_DR:
                            begin
                                // A read of an empty data register returns zero.
                                if (!fill_empty)
                                begin
                                    rsp_next.read_data = {24'b0, head_data};
                                    head_next = ptr_inc(head_reg);
                                    fill_next = fill_reg - FILL_W'(1);
                                    if (fill_reg == FILL_W'(1))
                                    begin
                                        rx_int_next = 1'b0;
                                    end
                                end
                            end
                            OFS_FR:
                            begin
                                rsp_next.read_data = FLAG_TXFE
                                    | (fill_empty ? FLAG_RXFE : 32'b0)
                                    | (fill_full ? FLAG_RXFF : 32'b0);
                            end
                            OFS_CR:   rsp_next.read_data = cr_reg;
                            OFS_LCRH: rsp_next.read_data = lcrh_reg;
                            OFS_IBRD: rsp_next.read_data = ibrd_reg;
                            OFS_FBRD: rsp_next.read_data = fbrd_reg;
                            OFS_IFLS: rsp_next.read_data = ifls_reg;
                            OFS_IMSC: rsp_next.read_data = imsc_reg;
                            OFS_RIS:  rsp_next.read_data = status_now;
                            OFS_MIS:  rsp_next.read_data = status_now & imsc_reg;
                            default:  rsp_next.read_data = '0;
                        endcase
                    end
                end
                OP_WRITE:
                begin
                    unique case (req.offset)
                        OFS_DR:
                        begin
                            tx_int_next      = 1'b1;
                            rsp_next.tx_valid = 1'b1;
                            rsp_next.tx_byte  = req.write_data[7:0] & BYTE_MASK;
                        end
                        OFS_CR:   cr_next   = req.write_data;
                        OFS_LCRH: lcrh_next = req.write_data;
                        OFS_IBRD: ibrd_next = req.write_data;
                        OFS_FBRD: fbrd_next = req.write_data;
                        OFS_IFLS: ifls_next = req.write_data;
                        OFS_IMSC: imsc_next = req.write_data;
                        OFS_ICR:
                        begin
                            rx_int_next = rx_int_reg && !req.write_data[INT_RX_BIT];
                            tx_int_next = tx_int_reg && !req.write_data[INT_TX_BIT];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                OP_PUSH:
                begin
                    // A byte arriving at a full FIFO is dropped.
                    if (!fill_full)
                    begin
                        ram_we      = 1'b1;
                        tail_next   = ptr_inc(tail_reg);
                        fill_next   = fill_reg + FILL_W'(1);
                        rx_int_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        status_after = '0;
        status_after[INT_RX_BIT] = rx_int_next;
        status_after[INT_TX_BIT] = tx_int_next;
        rsp_next.irq = |(status_after & imsc_next);
    end

    // The RAM is read at the next head; a write to that same entry is caught here.
    assign byp_hit_next  = ram_we && (tail_reg == head_next);
    assign byp_data_next = req.rx_byte;

    always_comb
    begin
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            rsp_valid_next = rsp_valid_reg;
        end
        else
        begin
            rsp_valid_next = 1'b0;
        end
    end

    urxf_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_rx_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (req.rx_byte),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            cr_reg        <= '0;
            lcrh_reg      <= '0;
            ibrd_reg      <= '0;
            fbrd_reg      <= '0;
            ifls_reg      <= '0;
            imsc_reg      <= '0;
            rx_int_reg    <= 1'b0;
            tx_int_reg    <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            cr_reg        <= cr_next;
            lcrh_reg      <= lcrh_next;
            ibrd_reg      <= ibrd_next;
            fbrd_reg      <= fbrd_next;
            ifls_reg      <= ifls_next;
            imsc_reg      <= imsc_next;
            rx_int_reg    <= rx_int_next;
            tx_int_reg    <= tx_int_next;
            byp_hit_reg   <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byp_data_next;
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The fill count never exceeds the FIFO depth.
    `URXF_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= FILL_W'(FIFO_DEPTH), "fill count overflow")
    // Head and tail meet exactly when the FIFO is empty or full.
    `URXF_ASSERT_SAME(a_ptr_match, 1'b1,
        (head_reg == tail_reg) == (fill_empty || fill_full), "pointers disagree with fill")
    // The receive interrupt cannot be pending while the FIFO is empty.
    `URXF_ASSERT_SAME(a_rx_int_empty, fill_empty, !rx_int_reg, "receive interrupt while empty")
    // With no response waiting, a request is never held off.
    `URXF_ASSERT_SAME(a_no_idle_stall, !rsp_valid_reg, !req_stall, "stall with empty response")

endmodule
